// File: design/jobs_pkg.sv
// Shared types and constants for the JSON object boundary scanner.
package jobs_pkg;

    typedef logic [2:0] t_status;
    typedef logic [7:0] t_byte;

    // Result status codes
    localparam t_status ST_SKIP       = 3'd0;
    localparam t_status ST_INSIDE     = 3'd1;
    localparam t_status ST_END        = 3'd2;
    localparam t_status ST_BADSTART   = 3'd3;
    localparam t_status ST_UNBAL      = 3'd4;
    localparam t_status ST_OVERFLOW   = 3'd5;
    localparam t_status ST_INCOMPLETE = 3'd6;
    localparam t_status ST_CLEAN      = 3'd7;

    // Character codes
    localparam t_byte CH_SPACE  = 8'h20;
    localparam t_byte CH_TAB    = 8'h09;
    localparam t_byte CH_LF     = 8'h0A;
    localparam t_byte CH_CR     = 8'h0D;
    localparam t_byte CH_LBRACE = 8'h7B;
    localparam t_byte CH_RBRACE = 8'h7D;
    localparam t_byte CH_LBRACK = 8'h5B;
    localparam t_byte CH_RBRACK = 8'h5D;
    localparam t_byte CH_QUOTE  = 8'h22;
    localparam t_byte CH_BSLASH = 8'h5C;

    // Width of the reported object length, saturating at its maximum
    localparam int OLEN_BITS = 16;

endpackage

// File: design/json_object_boundary_scanner_unit.sv
// An accepted request's result is registered into the output register in the cycle after acceptance.
// Throughput: one byte per cycle unless the result side stalls; the scan state updates in the
// same cycle the request is accepted, and the output register lets a new request in as the
// previous result is taken (ready = output empty or being taken).
// Reset (synchronous, active low): scanner seeks an object start, counts are zero,
// max_depth returns to 255, and the output register is emptied.
module json_object_boundary_scanner_unit #(
    parameter int DEPTH_BITS  = 8,
    parameter int LENGTH_BITS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // configuration
    input  logic                 i_max_depth_we,
    input  logic [7:0]           i_max_depth_wdata,
    // request channel
    input  logic                 i_valid,
    output logic                 o_ready,
    input  jobs_pkg::t_byte      i_byte_in,
    input  logic                 i_end_of_data,
    // result channel
    output logic                 o_valid,
    input  logic                 i_ready,
    output jobs_pkg::t_status    o_status,
    output jobs_pkg::t_byte      o_byte_out,
    output logic [15:0]          o_object_len
);
    import jobs_pkg::*;

    // compare width for depth limit check
    localparam int CW = (DEPTH_BITS + 1 > 8) ? DEPTH_BITS + 1 : 8;
    // width for length saturation
    localparam int XW = (LENGTH_BITS > OLEN_BITS) ? LENGTH_BITS : OLEN_BITS;

    // scan state
    logic                   r_inside, n_inside;
    logic                   r_in_str, n_in_str;
    logic                   r_esc, n_esc;
    logic [DEPTH_BITS-1:0]  r_brace, n_brace;
    logic [DEPTH_BITS-1:0]  r_bracket, n_bracket;
    logic [LENGTH_BITS-1:0] r_len, n_len;
    logic [7:0]             r_max_depth;

    // result register
    logic                   r_out_valid;
    t_status                r_status, n_status;
    t_byte                  r_byte, n_byte;
    logic [15:0]            r_olen, n_olen;

    logic                   accept;
    logic                   is_ws, is_open, is_close, is_brace;
    logic                   brace_ovf, bracket_ovf, open_ovf;
    logic [LENGTH_BITS-1:0] len_inc, len_src;
    logic [XW-1:0]          len_ext;
    logic [DEPTH_BITS-1:0]  cnt_cur, cnt_other;

    assign o_ready = !r_out_valid || i_ready;
    assign accept  = i_valid && o_ready;

    // byte classes
    always_comb begin
        is_ws    = (i_byte_in == CH_SPACE) || (i_byte_in == CH_TAB) ||
                   (i_byte_in == CH_LF) || (i_byte_in == CH_CR);
        is_open  = (i_byte_in == CH_LBRACE) || (i_byte_in == CH_LBRACK);
        is_close = (i_byte_in == CH_RBRACE) || (i_byte_in == CH_RBRACK);
        is_brace = (i_byte_in == CH_LBRACE) || (i_byte_in == CH_RBRACE);
    end

    // depth limit: next count above max_depth or above the counter's range
    always_comb begin
        brace_ovf   = (&r_brace) ||
                      ((CW'(r_brace) + CW'(1)) > CW'(r_max_depth));
        bracket_ovf = (&r_bracket) ||
                      ((CW'(r_bracket) + CW'(1)) > CW'(r_max_depth));
        open_ovf    = is_brace ? brace_ovf : bracket_ovf;
        cnt_cur     = is_brace ? r_brace : r_bracket;
        cnt_other   = is_brace ? r_bracket : r_brace;
        len_inc     = (&r_len) ? r_len : r_len + LENGTH_BITS'(1);
    end

    // next state and result
    always_comb begin
        n_inside  = r_inside;
        n_in_str  = r_in_str;
        n_esc     = r_esc;
        n_brace   = r_brace;
        n_bracket = r_bracket;
        n_len     = r_len;
        n_status  = ST_INSIDE;
        n_byte    = i_byte_in;
        len_src   = '0;

        if (i_end_of_data) begin
            n_byte = '0;
            if (r_inside) begin
                n_status  = ST_INCOMPLETE;
                len_src   = r_len;
                n_inside  = 1'b0;
                n_in_str  = 1'b0;
                n_esc     = 1'b0;
                n_brace   = '0;
                n_bracket = '0;
                n_len     = '0;
            end else begin
                n_status = ST_CLEAN;
            end
        end else if (!r_inside) begin
            // seeking: counts are zero here
            if (is_ws) begin
                n_status = ST_SKIP;
            end else if (is_open) begin
                len_src = LENGTH_BITS'(1);
                if (open_ovf) begin
                    n_status = ST_OVERFLOW;
                end else begin
                    n_status = ST_INSIDE;
                    n_inside = 1'b1;
                    n_len    = LENGTH_BITS'(1);
                    if (is_brace) begin
                        n_brace = r_brace + DEPTH_BITS'(1);
                    end else begin
                        n_bracket = r_bracket + DEPTH_BITS'(1);
                    end
                end
            end else begin
                n_status = ST_BADSTART;
            end
        end else begin
            // inside an object
            n_len   = len_inc;
            len_src = len_inc;
            if (r_esc) begin
                n_esc = 1'b0;
            end else if (i_byte_in == CH_BSLASH && r_in_str) begin
                n_esc = 1'b1;
            end else if (i_byte_in == CH_QUOTE) begin
                n_in_str = !r_in_str;
            end else if (!r_in_str) begin
                if (is_open) begin
                    if (open_ovf) begin
                        n_status = ST_OVERFLOW;
                    end else if (is_brace) begin
                        n_brace = r_brace + DEPTH_BITS'(1);
                    end else begin
                        n_bracket = r_bracket + DEPTH_BITS'(1);
                    end
                end else if (is_close) begin
                    if (cnt_cur == '0) begin
                        n_status = ST_UNBAL;
                    end else begin
                        if (is_brace) begin
                            n_brace = r_brace - DEPTH_BITS'(1);
                        end else begin
                            n_bracket = r_bracket - DEPTH_BITS'(1);
                        end
                        if (cnt_cur == DEPTH_BITS'(1) && cnt_other == '0) begin
                            n_status = ST_END;
                        end
                    end
                end
            end
            // any terminal status returns to seeking
            if (n_status != ST_INSIDE) begin
                n_inside  = 1'b0;
                n_in_str  = 1'b0;
                n_esc     = 1'b0;
                n_brace   = '0;
                n_bracket = '0;
                n_len     = '0;
            end
        end
    end

    // saturate reported length to 16 bits
    always_comb begin
        len_ext = XW'(len_src);
        n_olen  = (len_ext > XW'(16'hFFFF)) ? 16'hFFFF : len_ext[15:0];
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inside    <= 1'b0;
            r_in_str    <= 1'b0;
            r_esc       <= 1'b0;
            r_brace     <= '0;
            r_bracket   <= '0;
            r_len       <= '0;
            r_max_depth <= 8'd255;
            r_out_valid <= 1'b0;
        end else begin
            if (i_max_depth_we) begin
                r_max_depth <= i_max_depth_wdata;
            end
            if (accept) begin
                r_inside  <= n_inside;
                r_in_str  <= n_in_str;
                r_esc     <= n_esc;
                r_brace   <= n_brace;
                r_bracket <= n_bracket;
                r_len     <= n_len;
            end
            if (accept) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_status <= n_status;
            r_byte   <= n_byte;
            r_olen   <= n_olen;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_status     = r_status;
    assign o_byte_out   = r_byte;
    assign o_object_len = r_olen;

endmodule

// File: design/jobs_checker.sv
// Port-level checker for the JSON object boundary scanner, bound to the scanner unit.
module jobs_checker (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic              o_ready,
    input  logic              o_valid,
    input  logic              i_ready,
    input  jobs_pkg::t_status o_status,
    input  jobs_pkg::t_byte   o_byte_out,
    input  logic [15:0]       o_object_len
);
    import jobs_pkg::*;

    // reset empties the output register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    // a stalled result holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_status) &&
            $stable(o_byte_out) && $stable(o_object_len))
        else $error("stalled result changed");

    // every accepted request produces a result next cycle
    a_accept_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> o_valid)
        else $error("accepted request gave no result");

    // results outside an object carry zero length; an end spans at least two bytes
    a_len_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (((o_status != ST_SKIP) && (o_status != ST_BADSTART) &&
            (o_status != ST_CLEAN)) || (o_object_len == 16'd0)) &&
            ((o_status != ST_END) || (o_object_len >= 16'd2)))
        else $error("object length inconsistent with status");

endmodule

bind json_object_boundary_scanner_unit jobs_checker u_jobs_checker (.*);

// File: tb/sv/jobs_scan_checker.sv
// Scoreboard for the JSON object boundary scanner: tracks scan state and checks each result.
module jobs_scan_checker (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_max_depth_we,
    input  logic [7:0]        i_max_depth_wdata,
    input  logic              i_req_valid,
    input  logic              i_req_ready,
    input  jobs_pkg::t_byte   i_byte_in,
    input  logic              i_end_of_data,
    input  logic              i_res_valid,
    input  logic              i_res_ready,
    input  jobs_pkg::t_status i_status,
    input  jobs_pkg::t_byte   i_byte_out,
    input  logic [15:0]       i_object_len,
    output int                o_fail_count,
    output int                o_pending,
    output int                o_checked
);
    timeunit 1ns;
    timeprecision 1ps;
    import jobs_pkg::*;

    typedef struct packed {
        t_status     status;
        t_byte       data;
        logic [15:0] length;
    } t_scan_result;

    // Shadow copy of the scanner state
    bit          in_object;
    bit          in_quote;
    bit          esc_pend;
    int          brace_cnt;
    int          brack_cnt;
    logic [15:0] obj_len;
    int          depth_cap;

    t_scan_result owed_results[$];
    t_scan_result got;
    int           fails;
    int           checked;

    function automatic void clear_scan();
        in_object = 1'b0;
        in_quote  = 1'b0;
        esc_pend  = 1'b0;
        brace_cnt = 0;
        brack_cnt = 0;
        obj_len   = '0;
    endfunction

    // Next result of the scanner for one request; updates the shadow state
    function automatic t_scan_result scan_next_byte(t_byte b, logic eod);
        t_scan_result r;
        r.data = eod ? '0 : b;
        if (eod) begin
            r.status = in_object ? ST_INCOMPLETE : ST_CLEAN;
            r.length = in_object ? obj_len : '0;
            clear_scan();
            return r;
        end
        // seeking: whitespace, object start, or a bad start
        if (!in_object) begin
            r.length = '0;
            if (b inside {CH_SPACE, CH_TAB, CH_LF, CH_CR}) begin
                r.status = ST_SKIP;
            end else if (b == CH_LBRACE || b == CH_LBRACK) begin
                r.length = 16'd1;
                if (depth_cap < 1) begin
                    r.status = ST_OVERFLOW;
                end else begin
                    in_object = 1'b1;
                    obj_len   = 16'd1;
                    if (b == CH_LBRACE) brace_cnt = 1;
                    else brack_cnt = 1;
                    r.status = ST_INSIDE;
                end
            end else begin
                r.status = ST_BADSTART;
            end
            return r;
        end
        // inside an object: length saturates
        if (obj_len != 16'hFFFF) obj_len = obj_len + 16'd1;
        r.length = obj_len;
        r.status = ST_INSIDE;
        if (esc_pend) begin
            esc_pend = 1'b0;
        end else if (b == CH_BSLASH && in_quote) begin
            esc_pend = 1'b1;
        end else if (b == CH_QUOTE) begin
            in_quote = !in_quote;
        end else if (!in_quote) begin
            case (b)
                CH_LBRACE: begin
                    if (brace_cnt + 1 > depth_cap) begin
                        r.status = ST_OVERFLOW;
                        clear_scan();
                    end else begin
                        brace_cnt++;
                    end
                end
                CH_LBRACK: begin
                    if (brack_cnt + 1 > depth_cap) begin
                        r.status = ST_OVERFLOW;
                        clear_scan();
                    end else begin
                        brack_cnt++;
                    end
                end
                CH_RBRACE, CH_RBRACK: begin
                    if ((b == CH_RBRACE ? brace_cnt : brack_cnt) == 0) begin
                        r.status = ST_UNBAL;
                        clear_scan();
                    end else begin
                        if (b == CH_RBRACE) brace_cnt--;
                        else brack_cnt--;
                        if (brace_cnt == 0 && brack_cnt == 0) begin
                            r.status = ST_END;
                            clear_scan();
                        end
                    end
                end
                default: ;
            endcase
        end
        return r;
    endfunction

    // Compare taken results first (they belong to older requests), then predict new ones
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_scan();
            depth_cap = 255;
            owed_results.delete();
        end else begin
            if (i_res_valid && i_res_ready) begin
                if (owed_results.size() == 0) begin
                    $error("result taken with no request outstanding");
                    fails++;
                end else begin
                    got = owed_results.pop_front();
                    checked++;
                    if (i_status !== got.status) begin
                        $error("status: expected %0d, got %0d", got.status, i_status);
                        fails++;
                    end
                    if (i_byte_out !== got.data) begin
                        $error("byte_out: expected 0x%02h, got 0x%02h", got.data, i_byte_out);
                        fails++;
                    end
                    if (i_object_len !== got.length) begin
                        $error("object_len: expected %0d, got %0d",
                               got.length, i_object_len);
                        fails++;
                    end
                end
            end
            // a request at this edge still sees the old depth limit
            if (i_req_valid && i_req_ready)
                owed_results.push_back(scan_next_byte(i_byte_in, i_end_of_data));
            if (i_max_depth_we) depth_cap = int'(i_max_depth_wdata);
        end
        o_fail_count <= fails;
        o_pending    <= owed_results.size();
        o_checked    <= checked;
    end

endmodule

// File: tb/sv/json_object_boundary_scanner_unit_test.sv
// Testbench top for the JSON object boundary scanner: stimulus, flow control and verdict.
module json_object_boundary_scanner_unit_test;
    timeunit 1ns;
    timeprecision 1ps;
    import jobs_pkg::*;

    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int RX_HOLD       = 300;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_max_depth_we;
    logic [7:0]  i_max_depth_wdata;
    logic        i_valid;
    logic        o_ready;
    t_byte       i_byte_in;
    logic        i_end_of_data;
    logic        o_valid;
    logic        i_ready;
    t_status     o_status;
    t_byte       o_byte_out;
    logic [15:0] o_object_len;

    int fail_count;
    int pending;
    int checked;

    // Stimulus text: bit 8 marks an end-of-data request
    logic [8:0] text_q[$];
    int  sent;
    int  cfg_writes;
    int  cycles;
    bit  tx_quiet;
    bit  rx_quiet;
    int  hold_asked;
    int  hold_done;
    int  rx_wait;

    json_object_boundary_scanner_unit u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_max_depth_we   (i_max_depth_we),
        .i_max_depth_wdata(i_max_depth_wdata),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_byte_in        (i_byte_in),
        .i_end_of_data    (i_end_of_data),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_status         (o_status),
        .o_byte_out       (o_byte_out),
        .o_object_len     (o_object_len)
    );

    jobs_scan_checker u_chk (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_max_depth_we   (i_max_depth_we),
        .i_max_depth_wdata(i_max_depth_wdata),
        .i_req_valid      (i_valid),
        .i_req_ready      (o_ready),
        .i_byte_in        (i_byte_in),
        .i_end_of_data    (i_end_of_data),
        .i_res_valid      (o_valid),
        .i_res_ready      (i_ready),
        .i_status         (o_status),
        .i_byte_out       (o_byte_out),
        .i_object_len     (o_object_len),
        .o_fail_count     (fail_count),
        .o_pending        (pending),
        .o_checked        (checked)
    );

    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    // Run limit
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles, %0d results outstanding", cycles, pending);
            $display("== FAIL ==");
            $finish;
        end
    end

    // Mostly short stalls, now and then a long one
    function automatic int pick_stall();
        int r;
        r = $urandom_range(99);
        if (r < 70) return $urandom_range(1, 3);
        if (r < 95) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic int pick_gap();
        if (tx_quiet || $urandom_range(99) < 55) return 0;
        return pick_stall();
    endfunction

    // Result side: random back-pressure, plus long hold-offs on request
    initial begin
        i_ready <= 1'b0;
        rx_wait = 0;
        forever begin
            @(posedge i_clk);
            if (hold_asked != hold_done) begin
                hold_done++;
                rx_wait = RX_HOLD;
            end else if (rx_wait == 0 && !rx_quiet && $urandom_range(99) < 25) begin
                rx_wait = pick_stall();
            end
            if (rx_wait > 0) begin
                i_ready <= 1'b0;
                rx_wait--;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    // Text generation
    function automatic void put_byte(t_byte b);
        text_q.push_back({1'b0, b});
    endfunction

    function automatic void put_eod();
        text_q.push_back({1'b1, t_byte'($urandom_range(255))});
    endfunction

    function automatic t_byte any_space();
        case ($urandom_range(3))
            0: return CH_SPACE;
            1: return CH_TAB;
            2: return CH_LF;
            default: return CH_CR;
        endcase
    endfunction

    function automatic t_byte any_bracket();
        case ($urandom_range(3))
            0: return CH_LBRACE;
            1: return CH_RBRACE;
            2: return CH_LBRACK;
            default: return CH_RBRACK;
        endcase
    endfunction

    function automatic void gen_ws();
        repeat ($urandom_range(2)) put_byte(any_space());
    endfunction

    // Quoted string with escapes (any byte may follow a backslash) and brackets inside
    function automatic void gen_string();
        t_byte c;
        put_byte(CH_QUOTE);
        repeat ($urandom_range(6)) begin
            case ($urandom_range(9))
                0: begin
                    put_byte(CH_BSLASH);
                    put_byte(t_byte'($urandom_range(255)));
                end
                1: put_byte(any_bracket());
                default: begin
                    c = t_byte'($urandom_range(32, 126));
                    if (c == CH_QUOTE || c == CH_BSLASH) c = "a";
                    put_byte(c);
                end
            endcase
        end
        put_byte(CH_QUOTE);
    endfunction

    function automatic void gen_scalar();
        string word;
        case ($urandom_range(2))
            0: gen_string();
            1: begin
                if ($urandom_range(1)) put_byte("-");
                repeat ($urandom_range(1, 4)) put_byte(t_byte'("0" + $urandom_range(9)));
            end
            default: begin
                word = ($urandom_range(1)) ? "true" : "null";
                foreach (word[i]) put_byte(word[i]);
            end
        endcase
    endfunction

    function automatic void gen_value(int lvl);
        if (lvl <= 0 || $urandom_range(99) < 40) gen_scalar();
        else gen_container(lvl, $urandom_range(1));
    endfunction

    function automatic void gen_container(int lvl, bit as_obj);
        int members;
        members = $urandom_range(3);
        put_byte(as_obj ? CH_LBRACE : CH_LBRACK);
        for (int m = 0; m < members; m++) begin
            if (m > 0) put_byte(",");
            gen_ws();
            if (as_obj) begin
                gen_string();
                put_byte(":");
            end
            gen_value(lvl - 1);
        end
        gen_ws();
        put_byte(as_obj ? CH_RBRACE : CH_RBRACK);
    endfunction

    // One chunk: mostly well-formed objects, the rest broken or noise
    function automatic void gen_chunk(int cap);
        int r;
        int n;
        t_byte opener;
        r = $urandom_range(99);
        if (r < 60) begin
            gen_ws();
            gen_container($urandom_range(1, 4), $urandom_range(1));
            if ($urandom_range(7) == 0) put_eod();
        end else if (r < 70) begin
            // truncated object, then end of data
            gen_container($urandom_range(1, 3), $urandom_range(1));
            repeat ($urandom_range(1, text_q.size() - 1)) void'(text_q.pop_back());
            put_eod();
        end else if (r < 78) begin
            // stray closing byte somewhere in an object
            gen_container($urandom_range(1, 3), $urandom_range(1));
            text_q.insert($urandom_range(1, text_q.size() - 1),
                          {1'b0, ($urandom_range(1) ? CH_RBRACE : CH_RBRACK)});
        end else if (r < 86) begin
            // nesting at or just past a small depth limit, else shallow nesting
            n = (cap <= 6) ? cap + $urandom_range(1) : $urandom_range(1, 6);
            opener = $urandom_range(1) ? CH_LBRACE : CH_LBRACK;
            repeat (n) put_byte(opener);
            repeat (n) put_byte(opener == CH_LBRACE ? CH_RBRACE : CH_RBRACK);
        end else if (r < 95) begin
            repeat ($urandom_range(1, 8)) put_byte(t_byte'($urandom_range(255)));
        end else begin
            put_eod();
        end
    endfunction

    // Request side
    task automatic send_req(logic [8:0] item);
        int gap;
        i_valid       <= 1'b1;
        i_byte_in     <= item[7:0];
        i_end_of_data <= item[8];
        do @(posedge i_clk); while (!o_ready);
        sent++;
        gap = pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic flush_text();
        while (text_q.size() > 0) send_req(text_q.pop_front());
    endtask

    // Wait until every request has its result back
    task automatic drain();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (2) @(posedge i_clk);
    endtask

    task automatic write_depth_limit(logic [7:0] v);
        i_max_depth_we    <= 1'b1;
        i_max_depth_wdata <= v;
        @(posedge i_clk);
        i_max_depth_we    <= 1'b0;
        cfg_writes++;
    endtask

    task automatic run_phase(logic [7:0] cap, int budget, bit quiet_tx, bit quiet_rx,
                             bit squeeze, bit pause_mid, bit deep);
        int  done_items;
        bit  asked;
        bit  paused;
        drain();
        write_depth_limit(cap);
        tx_quiet   = quiet_tx;
        rx_quiet   = quiet_rx;
        done_items = 0;
        asked      = 1'b0;
        paused     = 1'b0;
        // one opening byte past the limit
        if (deep) begin
            repeat (int'(cap) + 1) put_byte(CH_LBRACE);
            put_eod();
            done_items += text_q.size();
            flush_text();
        end
        while (done_items < budget) begin
            gen_chunk(int'(cap));
            done_items += text_q.size();
            if (squeeze && !asked && done_items > budget / 4) begin
                hold_asked++;
                asked = 1'b1;
            end
            flush_text();
            if (pause_mid && !paused && done_items > budget / 2) begin
                drain();
                paused = 1'b1;
            end
        end
    endtask

    initial begin
        i_rst_n           <= 1'b0;
        i_max_depth_we    <= 1'b0;
        i_max_depth_wdata <= '0;
        i_valid           <= 1'b0;
        i_byte_in         <= '0;
        i_end_of_data     <= 1'b0;
        tx_quiet   = 1'b0;
        rx_quiet   = 1'b0;
        hold_asked = 0;
        hold_done  = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: whitespace, clean end, bad starts, empty object, incomplete end,
        // closes below zero, escaped quote in a string, overflow at a limit of one
        put_byte(CH_SPACE);
        put_byte(CH_TAB);
        put_byte(CH_LF);
        put_byte(CH_CR);
        put_eod();
        put_byte(8'h00);
        put_byte(8'hFF);
        put_byte(CH_LBRACE);
        put_byte(CH_RBRACE);
        put_byte(CH_LBRACK);
        put_eod();
        put_byte(CH_LBRACE);
        put_byte(CH_RBRACK);
        put_byte(CH_LBRACK);
        put_byte(CH_RBRACE);
        put_byte(CH_LBRACE);
        put_byte(CH_QUOTE);
        put_byte(CH_BSLASH);
        put_byte(CH_QUOTE);
        put_byte(CH_RBRACE);
        put_byte(CH_QUOTE);
        put_byte(CH_RBRACE);
        flush_text();
        drain();
        write_depth_limit(8'd1);
        put_byte(CH_LBRACK);
        put_byte(CH_LBRACK);
        flush_text();

        // Random phases over several depth limits
        run_phase(8'd255, 110, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
        run_phase(8'd1,   100, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0);
        run_phase(8'd2,   100, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0);
        run_phase(8'd4,   100, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0);
        run_phase(8'($urandom_range(5, 254)), 100, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0);
        run_phase(8'd255, 140, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1);

        drain();
        repeat (4) @(posedge i_clk);
        $display("Sent %0d requests under %0d depth-limit writes; %0d results compared.",
                 sent, cfg_writes, checked);
        $display("Mix: well-formed, truncated and corrupted objects, nesting past the limit,"
                 , " long output stalls and full-rate bursts.");
        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("%0d mismatches", fail_count);
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
